// ===== rtl/core/windowed_transfer_rate_estimator_core_defines.svh =====
// Assertion macros for the windowed transfer rate estimator RTL.
// Included by the modules that assert; needs nothing else.
`ifndef WINDOWED_TRANSFER_RATE_ESTIMATOR_CORE_DEFINES_SVH
`define WINDOWED_TRANSFER_RATE_ESTIMATOR_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define WTRE_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("wtre assertion failed");
// Check that a condition implies a consequence in the same cycle.
`define WTRE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("wtre implication failed");
// Check that a condition implies a consequence in the next cycle.
`define WTRE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("wtre sequence failed");
`else
`define WTRE_ASSERT(lbl, clk, rstn, prop)
`define WTRE_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define WTRE_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== rtl/core/wtre_pkg.sv =====
// Package of the windowed transfer rate estimator: constants and payload types.
// Depends on nothing.
package wtre_pkg;

  localparam int unsigned MaxWindow = 64;
  localparam int unsigned IdxW      = $clog2(MaxWindow);
  localparam int unsigned CntW      = $clog2(MaxWindow + 1);
  localparam int unsigned DepthW    = 7;
  localparam int unsigned SpeedW    = 42;
  localparam int unsigned EtaW      = 40;
  localparam int unsigned ProdW     = 64;
  localparam int unsigned DivCntW   = 6;
  localparam int unsigned AddrW     = 3;

  localparam logic [31:0]       MsPerSecond  = 32'd1000;
  localparam logic [DepthW-1:0] DepthAtReset = 7'd50;
  localparam logic [EtaW-1:0]   EtaLimit     = {EtaW{1'b1}};

  // Register index (word address bit)
  localparam logic RegExpected = 1'b0;
  localparam logic RegDepth    = 1'b1;

  // Request codes
  localparam logic ReqSample  = 1'b0;
  localparam logic ReqRestart = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [31:0] byte_total;
    logic [31:0] timestamp_ms;
  } wtre_in_t;

  typedef struct packed {
    logic              speed_valid;
    logic [SpeedW-1:0] speed_bps;
    logic              eta_valid;
    logic [EtaW-1:0]   eta_ms;
  } wtre_out_t;

  function automatic logic [CntW-1:0] clamp_depth(input logic [DepthW-1:0] v);
    logic [CntW-1:0] r;
    if (v < DepthW'(2)) begin
      r = CntW'(2);
    end else if (v > DepthW'(MaxWindow)) begin
      r = CntW'(MaxWindow);
    end else begin
      r = CntW'(v);
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/windowed_transfer_rate_estimator_core.sv =====
// Windowed transfer rate estimator. Each sample transfer (cumulative byte count
// plus millisecond timestamp) enters a 64-entry ring; the block answers every
// input transfer with exactly one result transfer: speed in bytes per second
// over the window and the estimated time left in ms until expected_size bytes
// arrive (saturating at 2^40-1). A restart transfer empties the ring and
// answers all zero. A full sample passes through check and first multiply,
// divider load, 42 divide steps, second multiply, saturation check and load,
// 40 divide steps and output, and a new sample is taken only once the last
// is through. Shorter paths: a restart goes straight to output; fewer than
// two samples or a zero time span leave after the check; a zero speed or a
// count past expected_size after the first division; a saturated time left
// after the saturation check. The single restoring divider retires one
// quotient bit per cycle and serves both divisions; in_stall_o stays high while
// it runs and until the result has moved to the output register.
// Results sit in an output register, so the next item is taken while a result
// still waits on out_stall_i. Registers: 0 expected_size at byte 0,
// 1 window_depth at byte 4 (clamped to 2..64; lowering it drops the oldest
// samples at once). Write registers only while the block is idle.
// Depends on wtre_pkg and windowed_transfer_rate_estimator_core_defines.svh.
`include "windowed_transfer_rate_estimator_core_defines.svh"

module windowed_transfer_rate_estimator_core (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  wtre_pkg::wtre_in_t     in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output wtre_pkg::wtre_out_t    out_data_o,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [wtre_pkg::AddrW-1:0] paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);
  import wtre_pkg::*;

  // Sequencer state codes
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CHK  = 3'd1;
  localparam logic [2:0] S_LD1  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_SPD  = 3'd4;
  localparam logic [2:0] S_LD2  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  // Sample ring: {timestamp, bytes} per entry
  logic [63:0] ring_mem [MaxWindow];

  logic [2:0]         state_q, state_d;
  logic [IdxW-1:0]    oldest_q;
  logic [CntW-1:0]    count_q;
  logic [31:0]        expected_q;
  logic [CntW-1:0]    depth_q;

  // Item working registers
  logic [31:0]        new_bytes_q, new_time_q;
  logic [31:0]        old_bytes_q, old_time_q;
  logic [31:0]        span_q, diff_q;
  logic [ProdW-1:0]   prod_q;
  wtre_out_t          res_q;

  // Shared divider
  logic [31:0]        rem_q, den_q;
  logic [SpeedW-1:0]  num_q, quo_q;
  logic [DivCntW-1:0] dcnt_q;
  logic               phase_q;

  wtre_out_t          out_q;
  logic               out_valid_q;

  // Handshakes
  logic in_fire, cfg_wr, out_free;
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_fire     = in_valid_i && !in_stall_o;
  assign cfg_wr      = psel && penable && pwrite && pready;
  assign pready      = 1'b1;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    unique case (paddr[2])
      RegExpected: prdata = expected_q;
      RegDepth:    prdata = 32'(depth_q);
      default:     prdata = '0;
    endcase
  end

  // Ring pointer arithmetic for an incoming sample
  logic [IdxW-1:0] wr_pos, oldest_new;
  logic [CntW-1:0] count_new;
  always_comb begin
    wr_pos = oldest_q + count_q[IdxW-1:0];
    if (count_q < depth_q) begin
      count_new  = count_q + CntW'(1);
      oldest_new = oldest_q;
    end else begin
      count_new  = count_q;
      oldest_new = oldest_q + IdxW'(1);
    end
  end

  // Depth write: clamp and drop the excess oldest samples
  logic [CntW-1:0] depth_wr, drop_cnt;
  assign depth_wr = clamp_depth(pwdata[DepthW-1:0]);
  assign drop_cnt = count_q - depth_wr;

  // Window differences and the shared multiplier
  logic [31:0]      span_c, diff_c, remain_c;
  logic [31:0]      mul_a, mul_b;
  logic [ProdW-1:0] mul_p;
  assign span_c   = new_time_q - old_time_q;
  assign diff_c   = new_bytes_q - old_bytes_q;
  assign remain_c = expected_q - new_bytes_q;

  always_comb begin
    if (state_q == S_CHK) begin
      mul_a = diff_c;
      mul_b = MsPerSecond;
    end else begin
      mul_a = remain_c;
      mul_b = span_q;
    end
    mul_p = ProdW'(mul_a) * ProdW'(mul_b);
  end

  // One restoring divide step
  logic [32:0]       div_trial;
  logic              div_ge;
  logic [31:0]       rem_next;
  logic [SpeedW-1:0] quo_next;
  always_comb begin
    div_trial = {rem_q, num_q[SpeedW-1]};
    div_ge    = (div_trial >= {1'b0, den_q});
    rem_next  = div_ge ? 32'(div_trial - {1'b0, den_q}) : div_trial[31:0];
    quo_next  = {quo_q[SpeedW-2:0], div_ge};
  end

  logic eta_sat;
  assign eta_sat = (32'(prod_q[ProdW-1:EtaW]) >= diff_q);

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_fire) state_d = (in_data_i.req_type == ReqRestart) ? S_OUT : S_CHK;
      S_CHK:  state_d = ((count_q >= CntW'(2)) && (span_c != '0)) ? S_LD1 : S_OUT;
      S_LD1:  state_d = S_DIV;
      S_DIV: begin
        if (dcnt_q == DivCntW'(1)) state_d = phase_q ? S_OUT : S_SPD;
      end
      S_SPD: begin
        state_d = ((quo_q != '0) && (expected_q >= new_bytes_q)) ? S_LD2 : S_OUT;
      end
      S_LD2:  state_d = eta_sat ? S_OUT : S_DIV;
      S_OUT:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      oldest_q    <= '0;
      count_q     <= '0;
      expected_q  <= '0;
      depth_q     <= clamp_depth(DepthAtReset);
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_wr) begin
        unique case (paddr[2])
          RegExpected: expected_q <= pwdata;
          RegDepth: begin
            depth_q <= depth_wr;
            if (count_q > depth_wr) begin
              oldest_q <= oldest_q + drop_cnt[IdxW-1:0];
              count_q  <= depth_wr;
            end
          end
          default: ;
        endcase
      end else if (in_fire) begin
        if (in_data_i.req_type == ReqRestart) begin
          oldest_q <= '0;
          count_q  <= '0;
        end else begin
          oldest_q <= oldest_new;
          count_q  <= count_new;
        end
      end
      if (state_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Ring write and oldest-entry read
  always_ff @(posedge clk_i) begin
    if (in_fire && in_data_i.req_type == ReqSample) begin
      ring_mem[wr_pos] <= {in_data_i.timestamp_ms, in_data_i.byte_total};
      {old_time_q, old_bytes_q} <= ring_mem[oldest_new];
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_OUT && out_free) begin
      out_q <= res_q;
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          new_bytes_q <= in_data_i.byte_total;
          new_time_q  <= in_data_i.timestamp_ms;
          res_q       <= '0;
        end
      end
      S_CHK: begin
        span_q <= span_c;
        diff_q <= diff_c;
        prod_q <= mul_p;
      end
      S_LD1: begin
        rem_q   <= '0;
        num_q   <= prod_q[SpeedW-1:0];
        quo_q   <= '0;
        den_q   <= span_q;
        dcnt_q  <= DivCntW'(SpeedW);
        phase_q <= 1'b0;
        res_q.speed_valid <= 1'b1;
      end
      S_DIV: begin
        rem_q  <= rem_next;
        num_q  <= num_q << 1;
        quo_q  <= quo_next;
        dcnt_q <= dcnt_q - DivCntW'(1);
        if (dcnt_q == DivCntW'(1)) begin
          if (phase_q) begin
            res_q.eta_ms <= quo_next[EtaW-1:0];
          end else begin
            res_q.speed_bps <= quo_next;
          end
        end
      end
      S_SPD: begin
        prod_q <= mul_p;
      end
      S_LD2: begin
        res_q.eta_valid <= 1'b1;
        if (eta_sat) begin
          res_q.eta_ms <= EtaLimit;
        end else begin
          // Quotient fits in 40 bits: start from the upper product bits
          rem_q   <= 32'(prod_q[ProdW-1:EtaW]);
          num_q   <= {prod_q[EtaW-1:0], {(SpeedW - EtaW){1'b0}}};
          quo_q   <= '0;
          den_q   <= diff_q;
          dcnt_q  <= DivCntW'(EtaW);
          phase_q <= 1'b1;
        end
      end
      S_OUT: ;
      default: ;
    endcase
  end

  `WTRE_ASSERT(a_count_in_window, clk_i, rst_ni, count_q <= depth_q)
  `WTRE_ASSERT(a_depth_range, clk_i, rst_ni,
    (depth_q >= CntW'(2)) && (depth_q <= CntW'(MaxWindow)))
  `WTRE_ASSERT_IMP(a_div_rem_below_den, clk_i, rst_ni, state_q == S_DIV, rem_q < den_q)
  `WTRE_ASSERT_IMP(a_eta_needs_speed, clk_i, rst_ni, out_valid_q && out_q.eta_valid,
    out_q.speed_valid && (out_q.speed_bps != '0))
  `WTRE_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_fire, in_stall_o)

endmodule

// ===== tb/wtre_rate_checker.sv =====
// Checker for the windowed transfer rate estimator: watches both channels and
// the register port, predicts each result and compares it field by field.
// Depends on wtre_pkg for the payload types and constants.
module wtre_rate_checker
  import wtre_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  wtre_in_t           in_data_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  wtre_out_t          out_data_i,
  input  logic               psel_i,
  input  logic               penable_i,
  input  logic               pwrite_i,
  input  logic               pready_i,
  input  logic [AddrW-1:0]   paddr_i,
  input  logic [31:0]        pwdata_i,
  output int unsigned        fail_count_o,
  output int unsigned        pending_o,
  output int unsigned        compared_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Predicted window state and register copies
  logic [31:0]       ring_bytes [MaxWindow];
  logic [31:0]       ring_times [MaxWindow];
  logic [IdxW-1:0]   oldest_slot;
  logic [CntW-1:0]   held;
  logic [CntW-1:0]   depth;
  logic [31:0]       expected_total;

  wtre_out_t         expected_rates [$];
  int unsigned       mismatches = 0;
  int unsigned       compared = 0;

  assign fail_count_o = mismatches;
  assign compared_o   = compared;

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    $display("%t mismatch in %s: got 0x%0h, want 0x%0h (result %0d)",
             $realtime, what, got, want, compared);
    mismatches++;
  endtask

  function automatic logic [CntW-1:0] limit_depth(input logic [DepthW-1:0] code);
    logic [CntW-1:0] kept;
    kept = (code > DepthW'(MaxWindow)) ? CntW'(MaxWindow) : CntW'(code);
    if (kept < CntW'(2)) kept = CntW'(2);
    return kept;
  endfunction

  // Advance the window by one transfer and return the speed and time-left figures.
  function automatic wtre_out_t forecast_rate(input wtre_in_t item);
    wtre_out_t       res;
    logic [IdxW-1:0] slot;
    logic [IdxW-1:0] newest;
    logic [31:0]     span;
    logic [31:0]     diff;
    logic [31:0]     remain;
    logic [63:0]     rate;
    logic [63:0]     left;
    res = '0;
    if (item.req_type == ReqRestart) begin
      oldest_slot = '0;
      held        = '0;
    end else begin
      slot = oldest_slot + IdxW'(held);
      ring_bytes[slot] = item.byte_total;
      ring_times[slot] = item.timestamp_ms;
      if (held < depth) held = held + 1'b1;
      else oldest_slot = oldest_slot + 1'b1;
      if (held >= CntW'(2)) begin
        newest = oldest_slot + IdxW'(held - 1'b1);
        span   = ring_times[newest] - ring_times[oldest_slot];
        diff   = ring_bytes[newest] - ring_bytes[oldest_slot];
        if (span != 0) begin
          rate = (64'(diff) * 64'(MsPerSecond)) / 64'(span);
          res.speed_valid = 1'b1;
          res.speed_bps   = rate[SpeedW-1:0];
          if (rate != 0 && expected_total >= ring_bytes[newest]) begin
            remain = expected_total - ring_bytes[newest];
            left   = (64'(remain) * 64'(span)) / 64'(diff);
            res.eta_valid = 1'b1;
            res.eta_ms    = (left > 64'(EtaLimit)) ? EtaLimit : left[EtaW-1:0];
          end
        end
      end
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    wtre_out_t want;
    if (!rst_ni) begin
      expected_rates.delete();
      oldest_slot    = '0;
      held           = '0;
      expected_total = '0;
      depth          = limit_depth(DepthAtReset);
      pending_o     <= 0;
    end else begin
      // Register writes must land only while idle; the block does not enforce it
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        if (paddr_i[AddrW-1] == RegExpected) begin
          expected_total = pwdata_i;
        end else begin
          depth = limit_depth(pwdata_i[DepthW-1:0]);
          while (held > depth) begin
            oldest_slot = oldest_slot + 1'b1;
            held        = held - 1'b1;
          end
        end
      end

      if (out_valid_i && !out_stall_i) begin
        if (expected_rates.size() == 0) begin
          flag_mismatch("result with nothing pending", 64'(out_data_i.speed_bps), '0);
        end else begin
          want = expected_rates[0];
          expected_rates.delete(0);
          if (out_data_i.speed_valid !== want.speed_valid)
            flag_mismatch("speed_valid", 64'(out_data_i.speed_valid), 64'(want.speed_valid));
          if (out_data_i.speed_bps !== want.speed_bps)
            flag_mismatch("speed_bps", 64'(out_data_i.speed_bps), 64'(want.speed_bps));
          if (out_data_i.eta_valid !== want.eta_valid)
            flag_mismatch("eta_valid", 64'(out_data_i.eta_valid), 64'(want.eta_valid));
          if (out_data_i.eta_ms !== want.eta_ms)
            flag_mismatch("eta_ms", 64'(out_data_i.eta_ms), 64'(want.eta_ms));
          compared++;
        end
      end

      if (in_valid_i && !in_stall_i) begin
        expected_rates.push_back(forecast_rate(in_data_i));
      end

      pending_o <= expected_rates.size();
    end
  end

endmodule

// ===== tb/tb.sv =====
// Top of the rate estimator testbench: clock, reset, stimulus, register writes
// and verdict. Depends on wtre_pkg, wtre_rate_checker and the estimator core.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wtre_pkg::*;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  wtre_in_t          in_data   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  wtre_out_t         out_data;
  logic              psel      = 1'b0;
  logic              penable   = 1'b0;
  logic              pwrite    = 1'b0;
  logic [AddrW-1:0]  paddr     = '0;
  logic [31:0]       pwdata    = '0;
  logic [31:0]       prdata;
  logic              pready;

  int unsigned       fails;
  int unsigned       pending;
  int unsigned       compared;

  // Set per phase: when high, neither side idles nor stalls
  bit                calm      = 1'b0;
  int unsigned       sent      = 0;
  int unsigned       restarts  = 0;
  int unsigned       writes    = 0;

  // Running byte count and clock of the well-formed transfer stream
  logic [31:0]       run_bytes = '0;
  logic [31:0]       run_time  = '0;

  // Depth codes for the first random phases: extremes and clamped values
  logic [DepthW-1:0] depth_plan [8] = '{7'd64, 7'd2, 7'd0, 7'd127,
                                        7'd3, 7'd65, 7'd1, 7'd33};

  windowed_transfer_rate_estimator_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  wtre_rate_checker checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .pready_i     (pready),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .fail_count_o (fails),
    .pending_o    (pending),
    .compared_o   (compared)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Hard stop, several times the slowest correct run
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic wtre_in_t sample_of(input logic [31:0] bytes_so_far,
                                         input logic [31:0] stamp);
    wtre_in_t item;
    item.req_type     = ReqSample;
    item.byte_total   = bytes_so_far;
    item.timestamp_ms = stamp;
    return item;
  endfunction

  function automatic wtre_in_t restart_item();
    wtre_in_t item;
    item.req_type     = ReqRestart;
    item.byte_total   = $urandom;
    item.timestamp_ms = $urandom;
    return item;
  endfunction

  // Offer one transfer after a random gap; return at the edge that takes it.
  // Keep valid high across back-to-back transfers so it is assigned once per step.
  task automatic send_item(input wtre_in_t item);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
    if (item.req_type == ReqRestart) restarts++;
  endtask

  // Drop valid and wait until every predicted result has been taken.
  // The extra edge lets the checker count the transfer just accepted.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Setup cycle, then access cycle; the write lands at the edge with pready high.
  // The bus then goes idle before returning, so the next write starts in a fresh step.
  task automatic write_reg(input logic index, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'({index, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    writes++;
  endtask

  // Result side: either take results at once, or hold stall high from the last
  // transfer until a result shows up and then for a random extra hold, so stalls
  // land both while the divider runs and while a result waits.
  initial begin : take_results
    int unsigned hold;
    wait (rst_n);
    @(posedge clk);
    forever begin
      hold = calm ? 0 : $urandom_range(0, 13);
      if (hold != 0) begin
        out_stall <= 1'b1;
        @(posedge clk);
        while (!out_valid) @(posedge clk);
        repeat (hold - 1) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin : stimulus
    wtre_in_t          item;
    logic [DepthW-1:0] depth_code;
    logic [31:0]       goal;
    int unsigned       pick;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset registers, empty window, single sample, zero span
    send_item(restart_item());
    send_item(sample_of(32'd0, 32'd0));
    send_item(sample_of(32'd0, 32'd0));
    send_item(sample_of(32'd5000, 32'd10));

    // Shrink the window to its minimum, which drops the oldest sample now held
    settle();
    write_reg(RegExpected, 32'hFFFF_FFFF);
    write_reg(RegDepth, 32'd2);
    send_item(sample_of(32'hFFFF_FFFF, 32'hFFFF_FFFF));
    // Bytes and time wrap past zero
    send_item(sample_of(32'd100, 32'd3));
    // Slowest nonzero speed with a huge remainder: time left saturates
    send_item(sample_of(32'd101, 32'd1003));
    // Same sample twice: zero span
    send_item(sample_of(32'd101, 32'd1003));
    // Time moves, bytes do not: speed zero, no time left
    send_item(sample_of(32'd101, 32'd2003));
    // Largest speed, expected size met exactly
    send_item(sample_of(32'd0, 32'd0));
    send_item(sample_of(32'hFFFF_FFFF, 32'd1));
    send_item(restart_item());
    send_item(sample_of(32'd7, 32'd7));

    // Depth code below range clamps to two; expected size below the count
    settle();
    write_reg(RegExpected, 32'd0);
    write_reg(RegDepth, 32'd0);
    send_item(sample_of(32'd10, 32'd1));
    send_item(sample_of(32'd20, 32'd2));

    // Depth code above range clamps to the full window
    settle();
    write_reg(RegExpected, 32'd1000);
    write_reg(RegDepth, 32'd127);
    for (int k = 1; k <= 6; k++) send_item(sample_of(32'(20 + 10 * k), 32'(2 + k)));

    // Lower the depth on a window of eight samples
    settle();
    write_reg(RegDepth, 32'd1);
    send_item(sample_of(32'd95, 32'd12));

    // Random phases: new depth and expected size each, then mostly a
    // well-formed growing transfer with restarts and arbitrary samples mixed in
    for (int phase = 0; phase < 12; phase++) begin
      settle();
      calm = ($urandom_range(0, 3) == 0);
      depth_code = (phase < 8) ? depth_plan[phase] : DepthW'($urandom_range(0, 127));
      write_reg(RegDepth, 32'(depth_code));
      case ($urandom_range(0, 3))
        0:       goal = 32'hFFFF_FFFF;
        1:       goal = run_bytes + $urandom_range(0, 1 << 16);
        2:       goal = $urandom;
        default: goal = run_bytes + $urandom;
      endcase
      write_reg(RegExpected, goal);

      for (int k = 0; k < 110; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
          item = restart_item();
          run_bytes = $urandom_range(0, 1 << 20);
        end else if (pick < 10) begin
          item = sample_of($urandom, $urandom);
        end else begin
          case ($urandom_range(0, 9))
            0:       run_time = run_time;
            1:       run_time = run_time + $urandom;
            default: run_time = run_time + $urandom_range(1, 2000);
          endcase
          case ($urandom_range(0, 9))
            0:       run_bytes = run_bytes;
            1:       run_bytes = run_bytes + $urandom;
            2, 3:    run_bytes = run_bytes + $urandom_range(0, 100);
            default: run_bytes = run_bytes + $urandom_range(0, 1 << 20);
          endcase
          item = sample_of(run_bytes, run_time);
        end
        send_item(item);
      end
    end

    // Drain, then give the block time for any stray result
    settle();
    repeat (100) @(posedge clk);

    $display("Covered %0d transfers in (%0d restarts) over %0d register writes,",
             sent, restarts, writes);
    $display("window depths from clamped low to clamped high; %0d results compared.",
             compared);
    if (fails == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== windowed_transfer_rate_estimator_core.f =====
+incdir+rtl/core
rtl/core/wtre_pkg.sv
rtl/core/windowed_transfer_rate_estimator_core.sv
tb/wtre_rate_checker.sv
tb/tb.sv
